// ===== rtl/core/b64c_pkg.sv =====
package b64c_pkg;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3d;

  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one queued unit of work: up to four results built from one aligned group
  typedef struct packed {
    logic        enc;      // 1: emit alphabet chars and pads, 0: emit bytes
    logic [23:0] v;        // group, left aligned (sextets or bytes from the top)
    logic [1:0]  n_out;    // number of results minus one
    logic [2:0]  n_valid;  // chars before padding (encode) / data bytes (decode)
    logic        last;
    logic        stop;
  } job_t;

  typedef struct packed {
    logic write;
    logic dir;
  } cfg_wr_t;

  // {bad, code}: bad set for any non-alphabet character
  function automatic logic [6:0] code_of(input logic [7:0] c);
    logic [6:0] r;
    r = {1'b1, 6'd0};
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2f) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] x);
    logic [7:0] r;
    if (x < 6'd26) begin
      r = 8'h41 + {2'b00, x};
    end else if (x < 6'd52) begin
      r = 8'h61 + {2'b00, x} - 8'd26;
    end else if (x < 6'd62) begin
      r = 8'h30 + {2'b00, x} - 8'd52;
    end else if (x == 6'd62) begin
      r = 8'h2b;
    end else begin
      r = 8'h2f;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/b64c_if.sv =====
interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_data;
  logic       out_last;
  logic       stopped_early;

  modport source (output valid, output out_byte, output has_data, output out_last,
                  output stopped_early, input ready);
  modport sink (input valid, input out_byte, input has_data, input out_last,
                input stopped_early, output ready);
endinterface

// ===== rtl/core/b64c_front.sv =====
module b64c_front (
  input  logic              clk,
  input  logic              rst,
  b64c_in_if.sink           in_ch,
  input  b64c_pkg::cfg_wr_t cfg_wr,
  output logic              direction,
  input  logic              q_full,
  output logic              push,
  output b64c_pkg::job_t    push_job
);
  import b64c_pkg::*;

  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic        decode_halted, decode_halted_next;

  logic        accept;
  logic        job_push;
  job_t        job;
  logic [23:0] shifted;
  logic [1:0]  cnt_inc;
  logic [6:0]  code;
  logic [23:0] dbits;
  logic [1:0]  dcnt;
  logic        dhalt;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    shifted  = {group_bits[15:0], in_ch.in_byte};
    cnt_inc  = group_count + 2'd1;
    code     = code_of(in_ch.in_byte);
    dbits    = group_bits;
    dcnt     = group_count;
    dhalt    = decode_halted;
    job      = '0;
    job_push = 1'b0;
    group_bits_next    = group_bits;
    group_count_next   = group_count;
    decode_halted_next = decode_halted;

    if (direction == DIR_ENCODE) begin
      if (cnt_inc == 2'd3 || in_ch.in_last) begin
        job_push    = 1'b1;
        job.enc     = 1'b1;
        job.n_out   = 2'd3;
        job.n_valid = {1'b0, cnt_inc} + 3'd1;
        job.last    = in_ch.in_last;
        case (cnt_inc)
          2'd1:    job.v = {shifted[7:0], 16'h0};
          2'd2:    job.v = {shifted[15:0], 8'h0};
          default: job.v = shifted;
        endcase
        group_bits_next  = '0;
        group_count_next = '0;
      end else begin
        group_bits_next  = shifted;
        group_count_next = cnt_inc;
      end
    end else begin
      if (!decode_halted) begin
        if (code[6]) begin
          dhalt = 1'b1;
        end else if (group_count == 2'd3) begin
          job_push    = 1'b1;
          job.v       = {group_bits[17:0], code[5:0]};
          job.n_out   = 2'd2;
          job.n_valid = 3'd3;
          job.last    = in_ch.in_last;
          dbits       = '0;
          dcnt        = '0;
        end else begin
          dbits = {group_bits[17:0], code[5:0]};
          dcnt  = group_count + 2'd1;
        end
      end
      // flush of a partial group, or a bare end marker
      if (in_ch.in_last && !job_push) begin
        job_push = 1'b1;
        job.last = 1'b1;
        if (dcnt >= 2'd2) begin
          job.n_out   = dcnt - 2'd2;
          job.n_valid = {1'b0, dcnt} - 3'd1;
          job.v       = (dcnt == 2'd2) ? {dbits[11:0], 12'h0} : {dbits[17:0], 6'h0};
        end
      end
      job.stop = dhalt;
      group_bits_next    = dbits;
      group_count_next   = dcnt;
      decode_halted_next = dhalt;
    end

    if (in_ch.in_last) begin
      group_bits_next    = '0;
      group_count_next   = '0;
      decode_halted_next = 1'b0;
    end
  end

  assign push     = accept && job_push;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= DIR_ENCODE;
      group_bits    <= '0;
      group_count   <= '0;
      decode_halted <= 1'b0;
    end else if (cfg_wr.write) begin
      direction     <= cfg_wr.dir;
      group_bits    <= '0;
      group_count   <= '0;
      decode_halted <= 1'b0;
    end else if (accept) begin
      group_bits    <= group_bits_next;
      group_count   <= group_count_next;
      decode_halted <= decode_halted_next;
    end
  end

endmodule

// ===== rtl/core/b64c_queue.sv =====
module b64c_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64c_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output b64c_pkg::job_t head_job
);
  import b64c_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/b64c_back.sv =====
module b64c_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  b64c_pkg::job_t head_job,
  output logic           pop,
  b64c_out_if.source     out_ch
);
  import b64c_pkg::*;

  logic [1:0] k;
  logic       issue;
  logic [5:0] sextet;
  logic [7:0] dbyte;
  logic [7:0] res_byte;
  logic       res_data;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       has_data;
  logic       out_last;
  logic       stopped_early;

  assign issue = head_valid && (!out_valid || out_ch.ready);
  assign pop   = issue && (k == head_job.n_out);

  always_comb begin
    case (k)
      2'd0:    sextet = head_job.v[23:18];
      2'd1:    sextet = head_job.v[17:12];
      2'd2:    sextet = head_job.v[11:6];
      default: sextet = head_job.v[5:0];
    endcase
    case (k)
      2'd0:    dbyte = head_job.v[23:16];
      2'd1:    dbyte = head_job.v[15:8];
      default: dbyte = head_job.v[7:0];
    endcase
    if (head_job.enc) begin
      res_data = 1'b1;
      res_byte = ({1'b0, k} < head_job.n_valid) ? char_of(sextet) : PAD_CHAR;
    end else begin
      res_data = (head_job.n_valid != 3'd0);
      res_byte = res_data ? dbyte : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
        k         <= pop ? 2'd0 : k + 2'd1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_byte      <= res_byte;
      has_data      <= res_data;
      out_last      <= head_job.last && (k == head_job.n_out);
      stopped_early <= head_job.stop;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.out_byte      = out_byte;
  assign out_ch.has_data      = has_data;
  assign out_ch.out_last      = out_last;
  assign out_ch.stopped_early = stopped_early;

endmodule

// ===== rtl/core/base64_codec_unit.sv =====
// Streaming Base64 codec, standard alphabet with '=' padding. Register 0
// (direction, byte address 0) selects encode (0) or decode (1); writing it
// also drops any partial group, so write it only between messages. Encode:
// each three bytes give four characters; the byte flagged in_last flushes a
// partial group as n+1 characters plus pads. Decode: alphabet characters are
// packed four to three bytes; the first '=' or other non-alphabet character
// halts the message (stopped_early set on its remaining results), and the
// last input flushes n characters as n-1 bytes, or gives one bare marker
// (has_data 0, out_last 1) when nothing is left. Timing: the front end takes
// one input per cycle into a four-entry job queue while it is not full; the
// back end emits one result per cycle from its output register while out_ch
// is ready. That port sets the pace: encode gives four results per three bytes,
// decode one input per cycle. Inputs pass the job queue, then the output register.
module base64_codec_unit (
  input  logic                          clk,
  input  logic                          rst,
  b64c_in_if.sink                       in_ch,
  b64c_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [b64c_pkg::PADDR_W-1:0]  paddr,
  input  logic [b64c_pkg::PDATA_W-1:0]  pwdata,
  output logic [b64c_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import b64c_pkg::*;

  cfg_wr_t cfg_wr;
  logic    direction;
  logic    q_full;
  logic    push;
  job_t    push_job;
  logic    pop;
  logic    head_valid;
  job_t    head_job;

  // APB: zero wait states; only the direction register exists (index in paddr[2])
  assign pready       = 1'b1;
  assign cfg_wr.write = psel && penable && pwrite && !paddr[PADDR_W-1];
  assign cfg_wr.dir   = pwdata[0];
  assign prdata       = paddr[PADDR_W-1] ? '0 : {{(PDATA_W-1){1'b0}}, direction};

  // front: group tracking, classify each transfer into a job (or none)
  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_wr    (cfg_wr),
    .direction (direction),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // decouples the input rate from the output, one result per cycle while out_ch is ready
  b64c_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: serializes each job into 1..4 results
  b64c_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
